FILE: sv/s2lab_pkg.sv
// ----------------------------------------------------------------------------
// s2lab_pkg
// Shared types, constants and the sRGB linearization table for the
// sRGB to CIELAB converter.
// ----------------------------------------------------------------------------
package s2lab_pkg;

	localparam int Q      = 30;
	localparam int LIN_W  = 31;
	localparam int XYZ_W  = 31;
	localparam int PROD_W = 54;

	// cycles through one constant divider
	localparam int DIV_LAT = 4;

	// matrix stage
	localparam int MAT_ROUND = 5000000;
	localparam int MAT_DEN   = 10000000;

	// white point stage
	localparam int WHT_W     = 48;
	localparam int WHT_SCALE = 100000;
	localparam int WX_ROUND  = 47523;
	localparam int WX_DEN    = 95047;
	localparam int WZ_ROUND  = 54441;
	localparam int WZ_DEN    = 108883;

	// companding
	localparam int CMP_W      = 47;
	localparam int CMP_MUL    = 24389;
	localparam int CMP_KNEE   = 216;
	localparam int CMP_OFS    = 432;
	localparam int CMP_ROUND  = 1566;
	localparam int CMP_DEN    = 3132;

	// lab outputs
	localparam int LAB_W = 42;

	typedef logic [23:0] coef_t;
	typedef coef_t mat_t [3][3];

	localparam mat_t MAT_COEF = '{
		'{24'd4124564, 24'd3575761, 24'd1804375},
		'{24'd2126729, 24'd7151522, 24'd721750},
		'{24'd193339,  24'd1191920, 24'd9503041}
	};

	typedef logic [LIN_W-1:0] lin_tab_t [256];

	function automatic logic [63:0] p5_q(input logic [63:0] y);
		logic [63:0] y2;
		logic [63:0] y4;
		y2 = (y * y) >> Q;
		y4 = (y2 * y2) >> Q;
		return (y4 * y) >> Q;
	endfunction

	// evaluated at elaboration only
	function automatic lin_tab_t build_lin_tab();
		lin_tab_t    tab;
		logic [63:0] one;
		logic [63:0] v;
		logic [63:0] v2;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		one = 64'd1 << Q;
		for (int c = 0; c < 256; c++) begin
			if (c <= 10) begin
				tab[c] = LIN_W'((64'(c) * 64'd10 * one + 64'd16473) / 64'd32946);
			end else begin
				v  = ((64'd1000 * 64'(c) + 64'd14025) * one + 64'd134512) / 64'd269025;
				v2 = (v * v) >> Q;
				lo = 64'd0;
				hi = one;
				while (lo < hi) begin
					mid = lo + (hi - lo + 64'd1) / 64'd2;
					if (p5_q(mid) <= v2) lo = mid;
					else hi = mid - 64'd1;
				end
				tab[c] = LIN_W'((v2 * lo) >> Q);
			end
		end
		return tab;
	endfunction

	localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage

FILE: sv/srgb_to_cielab_converter_top.sv
// ----------------------------------------------------------------------------
// srgb_to_cielab_converter_top
// Throughput: one pixel per cycle; busy is always low and done cannot stall.
// The latency is set by the three cube root lanes, two stages per result bit,
// and the reciprocal constant dividers. Reset clears only the valid pipeline.
// ----------------------------------------------------------------------------
module srgb_to_cielab_converter_top
	import s2lab_pkg::*;
#(
	parameter int LAB_FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        done,
	output logic [14:0] lightness,
	output logic signed [15:0] green_red_axis,
	output logic signed [15:0] blue_yellow_axis
);

	localparam int LAT   = 6 + 2 * DIV_LAT + 2 * XYZ_W + 2;
	localparam int SH    = Q - LAB_FRAC_BITS;
	localparam longint LMAX_RAW = longint'(100) << LAB_FRAC_BITS;
	localparam logic signed [LAB_W-1:0] LMAX =
		LAB_W'((LMAX_RAW > 32767) ? 32767 : LMAX_RAW);
	localparam logic signed [LAB_W-1:0] AMAX  = LAB_W'(32767);
	localparam logic signed [LAB_W-1:0] AMIN  = -LAB_W'(32768);
	localparam logic signed [LAB_W-1:0] HALF  = LAB_W'(1) << (SH - 1);
	localparam logic signed [LAB_W-1:0] LOFS  = LAB_W'(16) << Q;

	logic [LAT-1:0] vld_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	assign done = vld_q[LAT-1];

	// linearization table
	logic [LIN_W-1:0] lin_s1 [3];

	always_ff @(posedge clk) begin
		lin_s1[0] <= LIN_TAB[red];
		lin_s1[1] <= LIN_TAB[green];
		lin_s1[2] <= LIN_TAB[blue];
	end

	// matrix lanes
	logic [PROD_W-1:0] prod_s2 [3][3];
	logic [PROD_W-1:0] sum_s3  [3];
	logic [XYZ_W-1:0]  xyz     [3];

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_s2[r][c] <= PROD_W'(MAT_COEF[r][c]) * PROD_W'(lin_s1[c]);
			end
			sum_s3[r] <= prod_s2[r][0] + prod_s2[r][1] + prod_s2[r][2]
				+ PROD_W'(MAT_ROUND);
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_mat
		s2lab_div #(
			.NUM_W (PROD_W),
			.QUO_W (XYZ_W),
			.DEN   (MAT_DEN)
		) u_div (
			.clk (clk),
			.num (sum_s3[r]),
			.quo (xyz[r])
		);
	end

	// white point normalization
	logic [WHT_W-1:0] wx_s4;
	logic [WHT_W-1:0] wz_s4;
	logic [XYZ_W-1:0] y_s4;
	logic [XYZ_W-1:0] t_xyz [3];

	always_ff @(posedge clk) begin
		wx_s4 <= WHT_W'(xyz[0]) * WHT_W'(WHT_SCALE) + WHT_W'(WX_ROUND);
		wz_s4 <= WHT_W'(xyz[2]) * WHT_W'(WHT_SCALE) + WHT_W'(WZ_ROUND);
		y_s4  <= xyz[1];
	end

	s2lab_div #(.NUM_W(WHT_W), .QUO_W(XYZ_W), .DEN(WX_DEN)) u_wx (
		.clk (clk),
		.num (wx_s4),
		.quo (t_xyz[0])
	);

	s2lab_dly #(.W(XYZ_W), .N(DIV_LAT)) u_wy (
		.clk (clk),
		.d   (y_s4),
		.q   (t_xyz[1])
	);

	s2lab_div #(.NUM_W(WHT_W), .QUO_W(XYZ_W), .DEN(WZ_DEN)) u_wz (
		.clk (clk),
		.num (wz_s4),
		.quo (t_xyz[2])
	);

	// companding lanes
	logic [XYZ_W-1:0] f [3];

	for (genvar r = 0; r < 3; r++) begin : g_cmp
		s2lab_cmp u_cmp (
			.clk (clk),
			.t   (t_xyz[r]),
			.f   (f[r])
		);
	end

	// merge: L*, a*, b*
	logic signed [LAB_W-1:0] l_s5;
	logic signed [LAB_W-1:0] a_s5;
	logic signed [LAB_W-1:0] b_s5;
	logic signed [LAB_W-1:0] fx;
	logic signed [LAB_W-1:0] fy;
	logic signed [LAB_W-1:0] fz;

	assign fx = LAB_W'(f[0]);
	assign fy = LAB_W'(f[1]);
	assign fz = LAB_W'(f[2]);

	always_ff @(posedge clk) begin
		l_s5 <= fy * LAB_W'(116) - LOFS;
		a_s5 <= (fx - fy) * LAB_W'(500);
		b_s5 <= (fy - fz) * LAB_W'(200);
	end

	logic signed [LAB_W-1:0] l_r;
	logic signed [LAB_W-1:0] a_r;
	logic signed [LAB_W-1:0] b_r;

	// round half up, then floor shift
	assign l_r = (l_s5 + HALF) >>> SH;
	assign a_r = (a_s5 + HALF) >>> SH;
	assign b_r = (b_s5 + HALF) >>> SH;

	always_ff @(posedge clk) begin
		if (l_r < 0) lightness <= '0;
		else if (l_r > LMAX) lightness <= 15'(LMAX);
		else lightness <= 15'(l_r);

		if (a_r < AMIN) green_red_axis <= 16'(AMIN);
		else if (a_r > AMAX) green_red_axis <= 16'(AMAX);
		else green_red_axis <= 16'(a_r);

		if (b_r < AMIN) blue_yellow_axis <= 16'(AMIN);
		else if (b_r > AMAX) blue_yellow_axis <= 16'(AMAX);
		else blue_yellow_axis <= 16'(b_r);
	end

endmodule

FILE: sv/s2lab_dly.sv
// ----------------------------------------------------------------------------
// s2lab_dly
// Fixed-length delay line that keeps side data aligned with long units.
// ----------------------------------------------------------------------------
module s2lab_dly #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_q [N];

	always_ff @(posedge clk) begin
		tap_q[0] <= d;
		for (int i = 1; i < N; i++) begin
			tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[N-1];

endmodule

FILE: sv/s2lab_div.sv
// ----------------------------------------------------------------------------
// s2lab_div
// Pipelined divide by a constant: reciprocal multiply in three partial
// products, then one remainder correction.
// ----------------------------------------------------------------------------
module s2lab_div #(
	parameter int NUM_W = 54,
	parameter int QUO_W = 31,
	parameter longint DEN = 10
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	output logic [QUO_W-1:0] quo
);

	localparam int DEN_W = $clog2(DEN + 1);
	localparam int M_W   = NUM_W - DEN_W + 1;
	localparam int CH    = (NUM_W + 2) / 3;
	localparam int PP_W  = CH + M_W;
	localparam int SUM_W = 3 * CH + M_W;

	localparam logic [NUM_W-1:0] DEN_N = NUM_W'(DEN);
	localparam logic [NUM_W:0]   POW   = (NUM_W + 1)'(1) << NUM_W;
	localparam logic [NUM_W:0]   RECIP = POW / (NUM_W + 1)'(DEN);
	localparam logic [M_W-1:0]   M     = M_W'(RECIP);

	logic [3*CH-1:0]  num_x;
	logic [PP_W-1:0]  pp_s1 [3];
	logic [NUM_W-1:0] num_s1;
	logic [SUM_W-1:0] acc;
	logic [QUO_W-1:0] q0_s2;
	logic [NUM_W-1:0] num_s2;
	logic [NUM_W-1:0] prod_s3;
	logic [QUO_W-1:0] q0_s3;
	logic [NUM_W-1:0] num_s3;
	logic [NUM_W-1:0] rem;

	assign num_x = (3 * CH)'(num);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pp_s1[i] <= PP_W'(num_x[i*CH +: CH]) * PP_W'(M);
		end
		num_s1 <= num;
	end

	assign acc = SUM_W'(pp_s1[0]) + (SUM_W'(pp_s1[1]) << CH)
		+ (SUM_W'(pp_s1[2]) << (2 * CH));

	// estimate is the quotient or one below it
	always_ff @(posedge clk) begin
		q0_s2  <= QUO_W'(acc >> NUM_W);
		num_s2 <= num_s1;
	end

	always_ff @(posedge clk) begin
		prod_s3 <= NUM_W'(q0_s2) * DEN_N;
		q0_s3   <= q0_s2;
		num_s3  <= num_s2;
	end

	assign rem = num_s3 - prod_s3;

	always_ff @(posedge clk) begin
		quo <= (rem >= DEN_N) ? q0_s3 + QUO_W'(1) : q0_s3;
	end

endmodule

FILE: sv/s2lab_cbrt.sv
// ----------------------------------------------------------------------------
// s2lab_cbrt
// Pipelined Q30 cube root: bit-by-bit search, square and cube in two stages
// per result bit.
// ----------------------------------------------------------------------------
module s2lab_cbrt
	import s2lab_pkg::*;
(
	input  logic             clk,
	input  logic [XYZ_W-1:0] t,
	output logic [XYZ_W-1:0] root
);

	logic [XYZ_W-1:0] y_q [XYZ_W+1];
	logic [XYZ_W-1:0] t_q [XYZ_W+1];

	assign y_q[0] = '0;
	assign t_q[0] = t;

	for (genvar k = 0; k < XYZ_W; k++) begin : g_bit
		localparam int B = XYZ_W - 1 - k;
		logic [XYZ_W-1:0] cand;
		logic [31:0]      sq_q;
		logic [XYZ_W-1:0] cand_q;
		logic [XYZ_W-1:0] ya_q;
		logic [XYZ_W-1:0] ta_q;
		logic [63:0]      sq_full;
		logic [63:0]      cube;
		assign cand    = y_q[k] | (XYZ_W'(1) << B);
		assign sq_full = 64'(cand) * 64'(cand);
		always_ff @(posedge clk) begin
			sq_q   <= 32'(sq_full >> Q);
			cand_q <= cand;
			ya_q   <= y_q[k];
			ta_q   <= t_q[k];
		end
		assign cube = (64'(sq_q) * 64'(cand_q)) >> Q;
		always_ff @(posedge clk) begin
			y_q[k+1] <= (cube <= 64'(ta_q)) ? cand_q : ya_q;
			t_q[k+1] <= ta_q;
		end
	end

	assign root = y_q[XYZ_W];

endmodule

FILE: sv/s2lab_cmp.sv
// ----------------------------------------------------------------------------
// s2lab_cmp
// One companding lane: CIE f() with cube root and linear segment computed
// side by side, selected at the end.
// ----------------------------------------------------------------------------
module s2lab_cmp
	import s2lab_pkg::*;
(
	input  logic             clk,
	input  logic [XYZ_W-1:0] t,
	output logic [XYZ_W-1:0] f
);

	localparam logic [CMP_W-1:0] KNEE = CMP_W'(CMP_KNEE) << Q;
	localparam logic [CMP_W-1:0] OFS  = (CMP_W'(CMP_OFS) << Q) + CMP_W'(CMP_ROUND);

	logic [CMP_W-1:0] tm;
	logic [XYZ_W-1:0] t_s1;
	logic [CMP_W-1:0] num_s1;
	logic             root_s1;
	logic [XYZ_W-1:0] root;
	logic [XYZ_W-1:0] lin_quo;
	logic [XYZ_W-1:0] lin_d;
	logic             sel_d;

	assign tm = CMP_W'(t) * CMP_W'(CMP_MUL);

	always_ff @(posedge clk) begin
		t_s1    <= t;
		num_s1  <= tm + OFS;
		root_s1 <= tm > KNEE;
	end

	s2lab_cbrt u_cbrt (
		.clk  (clk),
		.t    (t_s1),
		.root (root)
	);

	s2lab_div #(
		.NUM_W (CMP_W),
		.QUO_W (XYZ_W),
		.DEN   (CMP_DEN)
	) u_div (
		.clk (clk),
		.num (num_s1),
		.quo (lin_quo)
	);

	s2lab_dly #(.W(XYZ_W), .N(2 * XYZ_W - DIV_LAT)) u_lin_dly (
		.clk (clk),
		.d   (lin_quo),
		.q   (lin_d)
	);

	s2lab_dly #(.W(1), .N(2 * XYZ_W)) u_sel_dly (
		.clk (clk),
		.d   (root_s1),
		.q   (sel_d)
	);

	always_ff @(posedge clk) begin
		f <= sel_d ? root : lin_d;
	end

endmodule
